// ----- rtl/hsde_pkg.sv -----
// Shared types and constants for the hall speed and direction estimator.
package hsde_pkg;

   // Field and register widths.
   localparam int SCALE_W  = 40;
   localparam int TICKS_W  = 40;
   localparam int STALL_W  = 32;
   localparam int PERIOD_W = 32;
   localparam int SPEED_W  = 16;

   // Configuration port geometry: 64-bit data, registers on 8-byte strides.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_LO = 3;
   localparam int CSR_IDX_W  = 2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_SCALE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_SPEED_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STALL_CUTOFF     = 2'd2;

   // Register reset values.
   localparam logic [SCALE_W-1:0] SPEED_SCALE_RST      = 40'd5000000000;
   localparam logic [TICKS_W-1:0] ZERO_SPEED_TICKS_RST = 40'd12500000;
   localparam logic [STALL_W-1:0] STALL_CUTOFF_RST     = 32'd1000;

   // Saturation limits.
   localparam logic [TICKS_W-1:0] ELAPSED_MAX = {TICKS_W{1'b1}};
   localparam logic [STALL_W-1:0] STALL_MAX   = {STALL_W{1'b1}};
   localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};

   // Divider: one quotient bit per step.
   localparam int DIV_STEPS = SCALE_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Item kinds.
   typedef enum logic [1:0] {
      MODE_TICK       = 2'd0,
      MODE_U_EDGE     = 2'd1,
      MODE_OTHER_EDGE = 2'd2,
      MODE_QUERY      = 2'd3
   } mode_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DONE
   } seq_state_type;

   // Input word.
   typedef struct packed {
      mode_type              mode;
      logic                  hall_w_level;
      logic [PERIOD_W-1:0]   capture_period;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [SPEED_W-1:0] speed_mph_q8;
      logic               direction;
      logic               ready_res;
      logic               stopped;
   } rsp_word_type;

   // Divider handshake between the sequencer and the divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/hall_speed_direction_estimator.sv -----
// Top level of the hall speed and direction estimator.
// Each input word is a timer tick, a phase-U rising edge, another hall edge or a speed
// query, and each one produces exactly one result word carrying speed, direction, ready
// and stopped. Ticks and hall edges update the tracking state as they are accepted, then
// pass through the done state to load the output register. A query on a running motor
// with a nonzero period divides speed_scale by capture_period in a restoring divider that
// retires one quotient bit per clock; its result passes through the divider's 40 steps,
// the sequencer seeing the divider finish and the load of the output register. Queries
// that read zero (stopped or zero period) skip the divider and go straight to the done
// state. An output stall holds a word in the done state until the output register is free.
// The block takes one word at a time; a new word is accepted once the previous result has
// moved into the output register, even if that result has not yet been taken. The three
// configuration registers sit at byte addresses 0, 8 and 16 of the CSR port, are 64 bits
// wide on the bus and should be written only while the block is idle.
module hall_speed_direction_estimator
   import hsde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   seq_state_type         state_ff, state_in;

   logic [SCALE_W-1:0]    speed_scale_ff, speed_scale_in;
   logic [TICKS_W-1:0]    zero_ticks_ff, zero_ticks_in;
   logic [STALL_W-1:0]    stall_cutoff_ff, stall_cutoff_in;

   logic [TICKS_W-1:0]    elapsed_ff, elapsed_in;
   logic [STALL_W-1:0]    stall_ff, stall_in;
   logic                  ready_flag_ff, ready_flag_in;
   logic                  dir_flag_ff, dir_flag_in;

   logic [SPEED_W-1:0]    speed_ff, speed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  req_fire;
   logic                  stopped_now;
   logic                  div_start;
   logic                  load_rsp;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic                  csr_wr;
   div_status_type        div_status;
   logic [SCALE_W-1:0]    div_quotient;
   logic [SPEED_W-1:0]    speed_sat;

   assign req_fire    = req_valid && req_ready;
   assign stopped_now = elapsed_ff > zero_ticks_ff;
   assign csr_idx     = csr_paddr[CSR_IDX_LO +: CSR_IDX_W];
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Shared divider for speed queries.
   hsde_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (speed_scale_ff),
      .divisor  (req_word.capture_period),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Saturate the quotient to the 16-bit speed range.
   assign speed_sat = (|div_quotient[SCALE_W-1:SPEED_W]) ? SPEED_MAX
                                                         : div_quotient[SPEED_W-1:0];

   // Sequencer outputs.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      div_start = (state_ff == ST_IDLE) && req_valid && (req_word.mode == MODE_QUERY) &&
                  !stopped_now && (req_word.capture_period != '0);
      load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = div_start ? ST_DIVIDE : ST_DONE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Tracking state: counters, ready and direction flags.
   always_comb begin
      elapsed_in    = elapsed_ff;
      stall_in      = stall_ff;
      ready_flag_in = ready_flag_ff;
      dir_flag_in   = dir_flag_ff;
      if (req_fire) begin
         case (req_word.mode)
            MODE_TICK: begin
               if (elapsed_ff != ELAPSED_MAX) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
               if (stall_ff != STALL_MAX) begin
                  stall_in = stall_ff + 1'b1;
               end
            end
            MODE_U_EDGE: begin
               ready_flag_in = stall_ff <= stall_cutoff_ff;
               dir_flag_in   = !req_word.hall_w_level;
               stall_in      = '0;
               elapsed_in    = '0;
            end
            MODE_OTHER_EDGE: begin
               elapsed_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Speed held for the result: zero unless the divider finishes a query.
   always_comb begin
      speed_in = speed_ff;
      if (req_fire) begin
         speed_in = '0;
      end else if ((state_ff == ST_DIVIDE) && div_status.done) begin
         speed_in = speed_sat;
      end
   end

   // Output register; flags are sampled after the word's update.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (load_rsp) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.speed_mph_q8 = speed_ff;
         rsp_word_in.direction    = dir_flag_ff;
         rsp_word_in.ready_res    = ready_flag_ff;
         rsp_word_in.stopped      = stopped_now;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration register writes.
   always_comb begin
      speed_scale_in  = speed_scale_ff;
      zero_ticks_in   = zero_ticks_ff;
      stall_cutoff_in = stall_cutoff_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_SPEED_SCALE:      speed_scale_in  = csr_pwdata[SCALE_W-1:0];
            REG_ZERO_SPEED_TICKS: zero_ticks_in   = csr_pwdata[TICKS_W-1:0];
            REG_STALL_CUTOFF:     stall_cutoff_in = csr_pwdata[STALL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Configuration register reads.
   always_comb begin
      case (csr_idx)
         REG_SPEED_SCALE:      csr_prdata = CSR_DATA_W'(speed_scale_ff);
         REG_ZERO_SPEED_TICKS: csr_prdata = CSR_DATA_W'(zero_ticks_ff);
         REG_STALL_CUTOFF:     csr_prdata = CSR_DATA_W'(stall_cutoff_ff);
         default:              csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // Control, configuration and tracking state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         speed_scale_ff  <= SPEED_SCALE_RST;
         zero_ticks_ff   <= ZERO_SPEED_TICKS_RST;
         stall_cutoff_ff <= STALL_CUTOFF_RST;
         elapsed_ff      <= ELAPSED_MAX;
         stall_ff        <= STALL_MAX;
         ready_flag_ff   <= 1'b0;
         dir_flag_ff     <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         speed_scale_ff  <= speed_scale_in;
         zero_ticks_ff   <= zero_ticks_in;
         stall_cutoff_ff <= stall_cutoff_in;
         elapsed_ff      <= elapsed_in;
         stall_ff        <= stall_in;
         ready_flag_ff   <= ready_flag_in;
         dir_flag_ff     <= dir_flag_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      speed_ff    <= speed_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef NO_ASSERTIONS
   // The divider only finishes while the sequencer is waiting for it.
   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide state");

   // A U edge clears both counters.
   a_u_edge_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_word.mode == MODE_U_EDGE)) |=> (elapsed_ff == '0 && stall_ff == '0))
      else $error("U edge did not clear the counters");

   // A tick never moves the elapsed count backward.
   a_tick_monotonic: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_word.mode == MODE_TICK)) |=> (elapsed_ff >= $past(elapsed_ff)))
      else $error("tick decreased the elapsed count");

   // A zero-period query skips the divider and reads zero.
   a_zero_period_skip: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_word.mode == MODE_QUERY) && (req_word.capture_period == '0))
      |=> (state_ff == ST_DONE && speed_ff == '0))
      else $error("zero-period query did not read zero");
`endif

endmodule

// ----- rtl/hsde_divider.sv -----
// Iterative restoring divider, one quotient bit per clock.
module hsde_divider
   import hsde_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SCALE_W-1:0]   dividend,
   input  logic [PERIOD_W-1:0]  divisor,
   output div_status_type       status,
   output logic [SCALE_W-1:0]   quotient
);

   logic [PERIOD_W-1:0]  rem_ff, rem_in;
   logic [SCALE_W-1:0]   quot_ff, quot_in;
   logic [PERIOD_W-1:0]  divisor_ff, divisor_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [PERIOD_W:0]    rem_shift;
   logic [PERIOD_W:0]    rem_diff;
   logic                 fits;

   // One step: shift in the next dividend bit and try to subtract.
   // The partial remainder stays below twice the divisor, so the top bit of the
   // difference is set exactly when the subtraction borrows.
   always_comb begin
      rem_shift = {rem_ff, quot_ff[SCALE_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor_ff};
      fits      = !rem_diff[PERIOD_W];
   end

   // Next values of the datapath and step counter.
   always_comb begin
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = '0;
         quot_in    = dividend;
         divisor_in = divisor;
         cnt_in     = DIV_CNT_W'(DIV_STEPS - 1);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_diff[PERIOD_W-1:0] : rem_shift[PERIOD_W-1:0];
         quot_in = {quot_ff[SCALE_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // Control state is reset; the datapath is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule
